// ===== design/bpc_pkg.sv =====
// Package for the button press classifier: widths, register and event codes,
// card colour table, saturating timer increment and shared structs.
// No dependencies.
package bpc_pkg;

  localparam int TIMER_WIDTH = 16;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = 16;
  localparam int COLOR_WIDTH = 8;
  localparam int LEVEL_WIDTH = 8;

  typedef logic [TIMER_WIDTH-1:0] timer_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_DEBOUNCE    = 3'd0,
    REG_MIN_CLICK   = 3'd1,
    REG_LONG_PRESS  = 3'd2,
    REG_REBOOT_HOLD = 3'd3,
    REG_BLINK_HALF  = 3'd4,
    REG_CARD_COLOR  = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_ENTER = 2'd1,
    EV_LEAVE = 2'd2
  } pair_event_t;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_FORCE = 1'b1;

  localparam logic MODE_IDLE    = 1'b0;
  localparam logic MODE_PAIRING = 1'b1;

  localparam logic LEVEL_PRESSED  = 1'b0;
  localparam logic LEVEL_RELEASED = 1'b1;

  typedef struct packed {
    logic [LEVEL_WIDTH-1:0] red;
    logic [LEVEL_WIDTH-1:0] green;
    logic [LEVEL_WIDTH-1:0] blue;
  } led_t;

  localparam led_t LED_OFF  = '{red: 8'd0,   green: 8'd0, blue: 8'd0};
  localparam led_t LED_RED  = '{red: 8'd255, green: 8'd0, blue: 8'd0};
  localparam led_t LED_BLUE = '{red: 8'd0,   green: 8'd0, blue: 8'd255};

  typedef struct packed {
    timer_t                 debounce;
    timer_t                 min_click;
    timer_t                 long_press;
    timer_t                 reboot_hold;
    timer_t                 blink_half;
    logic [COLOR_WIDTH-1:0] card_color;
  } cfg_t;

  typedef struct packed {
    logic                   mode;
    pair_event_t            pairing_event;
    logic                   power_off_request;
    logic                   reboot_request;
    logic [LEVEL_WIDTH-1:0] red_drive;
    logic [LEVEL_WIDTH-1:0] green_drive;
    logic [LEVEL_WIDTH-1:0] blue_drive;
  } result_t;

  localparam timer_t TIMER_MAX = {TIMER_WIDTH{1'b1}};

  function automatic timer_t sat_inc(input timer_t v);
    return (v == TIMER_MAX) ? v : v + timer_t'(1);
  endfunction

  function automatic led_t card_led(input logic [COLOR_WIDTH-1:0] code);
    led_t c;
    unique case (code)
      8'd1:    c = '{red: 8'd255, green: 8'd0,   blue: 8'd255};
      8'd2:    c = '{red: 8'd128, green: 8'd0,   blue: 8'd128};
      8'd3:    c = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
      8'd4:    c = '{red: 8'd0,   green: 8'd128, blue: 8'd255};
      8'd5:    c = '{red: 8'd64,  green: 8'd224, blue: 8'd208};
      8'd6:    c = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
      8'd7:    c = '{red: 8'd255, green: 8'd255, blue: 8'd0};
      8'd8:    c = '{red: 8'd255, green: 8'd165, blue: 8'd0};
      8'd9:    c = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
      default: c = '{red: 8'd255, green: 8'd255, blue: 8'd255};
    endcase
    return c;
  endfunction

endpackage

// ===== design/button_press_classifier_led_status.sv =====
// Latency: a result is valid the cycle after its input word is accepted.
// Throughput: one word per cycle unless a stalled result holds the output; the output register
// accepts a new word while the previous result is taken in the same cycle.
// Reset: synchronous; state clears to idle, released, LED off (drives 255) and
// the registers return to 50, 50, 3000, 10000, 500 and colour 0.
module button_press_classifier_led_status (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bpc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [bpc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                operation,
  input  logic                                button_raw,
  input  logic                                forced_mode,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                mode,
  output logic [1:0]                          pairing_event,
  output logic                                power_off_request,
  output logic                                reboot_request,
  output logic [7:0]                          red_drive,
  output logic [7:0]                          green_drive,
  output logic [7:0]                          blue_drive
);
  import bpc_pkg::*;

  cfg_t    cfg;
  result_t res, out_reg;
  logic    step;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign step      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce    <= timer_t'(50);
      cfg.min_click   <= timer_t'(50);
      cfg.long_press  <= timer_t'(3000);
      cfg.reboot_hold <= timer_t'(10000);
      cfg.blink_half  <= timer_t'(500);
      cfg.card_color  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DEBOUNCE:    cfg.debounce    <= timer_t'(cfg_data);
        REG_MIN_CLICK:   cfg.min_click   <= timer_t'(cfg_data);
        REG_LONG_PRESS:  cfg.long_press  <= timer_t'(cfg_data);
        REG_REBOOT_HOLD: cfg.reboot_hold <= timer_t'(cfg_data);
        REG_BLINK_HALF:  cfg.blink_half  <= timer_t'(cfg_data);
        REG_CARD_COLOR:  cfg.card_color  <= cfg_data[COLOR_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  bpc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .step        (step),
    .operation   (operation),
    .button_raw  (button_raw),
    .forced_mode (forced_mode),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) out_reg <= res;
  end

  assign mode              = out_reg.mode;
  assign pairing_event     = out_reg.pairing_event;
  assign power_off_request = out_reg.power_off_request;
  assign reboot_request    = out_reg.reboot_request;
  assign red_drive         = out_reg.red_drive;
  assign green_drive       = out_reg.green_drive;
  assign blue_drive        = out_reg.blue_drive;

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_reg))
    else $error("stalled result word changed");

  a_accept_shows: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("accepted word produced no result");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled with output free");

endmodule

// ===== design/bpc_core.sv =====
// Debounce, press timing, mode and LED state for the button press classifier.
// Computes one result per stepped word in a single pass. Depends on bpc_pkg.
module bpc_core (
  input  logic             clk,
  input  logic             rst,
  input  bpc_pkg::cfg_t    cfg,
  input  logic             step,
  input  logic             operation,
  input  logic             button_raw,
  input  logic             forced_mode,
  output bpc_pkg::result_t res
);
  import bpc_pkg::*;

  logic   mode_reg, last_raw, stable_level, held, long_done, blink_off;
  timer_t since_change, press_length, blink_phase_count;
  led_t   led_level;

  logic   mode_reg_next, last_raw_next, stable_level_next, held_next;
  logic   long_done_next, blink_off_next;
  timer_t since_change_next, press_length_next, blink_phase_count_next;
  led_t   led_level_next;
  pair_event_t ev;
  logic   poweroff, reboot;

  always_comb begin
    mode_reg_next          = mode_reg;
    last_raw_next          = last_raw;
    stable_level_next      = stable_level;
    held_next              = held;
    long_done_next         = long_done;
    blink_off_next         = blink_off;
    since_change_next      = since_change;
    press_length_next      = press_length;
    blink_phase_count_next = blink_phase_count;
    led_level_next         = led_level;
    ev       = EV_NONE;
    poweroff = 1'b0;
    reboot   = 1'b0;

    if (operation == OP_FORCE) begin
      mode_reg_next = forced_mode;
    end else begin
      if (held) press_length_next = sat_inc(press_length);
      since_change_next = (button_raw != last_raw) ? '0 : sat_inc(since_change);

      if (since_change_next > cfg.debounce && button_raw != stable_level) begin
        stable_level_next = button_raw;
        if (button_raw == LEVEL_PRESSED) begin
          held_next         = 1'b1;
          long_done_next    = 1'b0;
          press_length_next = '0;
        end else begin
          held_next = 1'b0;
          if (!long_done && press_length_next > cfg.min_click) begin
            if (press_length_next <= cfg.long_press) begin
              mode_reg_next = ~mode_reg;
              ev = (mode_reg_next == MODE_PAIRING) ? EV_ENTER : EV_LEAVE;
            end else if (press_length_next <= cfg.reboot_hold) begin
              long_done_next = 1'b1;
              poweroff       = 1'b1;
            end
          end
        end
      end

      if (held_next && !long_done_next) begin
        if (press_length_next > cfg.reboot_hold) begin
          long_done_next = 1'b1;
          reboot         = 1'b1;
          led_level_next = LED_BLUE;
        end else if (press_length_next > cfg.long_press) begin
          led_level_next = LED_RED;
        end
      end

      if (!(held_next && press_length_next > cfg.long_press)) begin
        if (mode_reg_next == MODE_IDLE || !blink_off) begin
          led_level_next = card_led(cfg.card_color);
        end else begin
          led_level_next = LED_OFF;
        end
      end

      blink_phase_count_next = sat_inc(blink_phase_count);
      if (blink_phase_count_next >= cfg.blink_half) begin
        blink_phase_count_next = '0;
        blink_off_next         = ~blink_off;
      end

      last_raw_next = button_raw;
    end

    res.mode              = mode_reg_next;
    res.pairing_event     = ev;
    res.power_off_request = poweroff;
    res.reboot_request    = reboot;
    res.red_drive         = ~led_level_next.red;
    res.green_drive       = ~led_level_next.green;
    res.blue_drive        = ~led_level_next.blue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg          <= MODE_IDLE;
      last_raw          <= LEVEL_RELEASED;
      stable_level      <= LEVEL_RELEASED;
      held              <= 1'b0;
      long_done         <= 1'b0;
      blink_off         <= 1'b0;
      since_change      <= '0;
      press_length      <= '0;
      blink_phase_count <= '0;
      led_level         <= LED_OFF;
    end else if (step) begin
      mode_reg          <= mode_reg_next;
      last_raw          <= last_raw_next;
      stable_level      <= stable_level_next;
      held              <= held_next;
      long_done         <= long_done_next;
      blink_off         <= blink_off_next;
      since_change      <= since_change_next;
      press_length      <= press_length_next;
      blink_phase_count <= blink_phase_count_next;
      led_level         <= led_level_next;
    end
  end

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    !(res.power_off_request && res.reboot_request))
    else $error("power-off and reboot requested together");

  a_event_mode: assert property (@(posedge clk) disable iff (rst)
    (res.pairing_event == EV_ENTER) |-> (res.mode == MODE_PAIRING))
    else $error("pairing entered but mode is idle");

  a_force_quiet: assert property (@(posedge clk) disable iff (rst)
    (operation == OP_FORCE) |->
      (res.pairing_event == EV_NONE && !res.power_off_request && !res.reboot_request))
    else $error("force word reported an event");

  a_reboot_once: assert property (@(posedge clk) disable iff (rst)
    (step && res.reboot_request) |=> !res.reboot_request || $past(button_raw) != 1'b0
      || long_done)
    else $error("reboot requested twice in one press");

endmodule
